// ----- rtl/wps_pkg.sv -----
package wps_pkg;

	localparam int LENGTH_BITS_DEF   = 32;
	localparam int CAPTURE_BYTES_DEF = 10;

	localparam logic [1:0] REG_IMAGE_LENGTH  = 2'd0;
	localparam logic [1:0] REG_MEMORY_BUDGET = 2'd1;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_INVALID   = 3'd1;
	localparam logic [2:0] STATUS_TOO_LARGE = 3'd2;
	localparam logic [2:0] STATUS_MEM_LIMIT = 3'd3;
	localparam logic [2:0] STATUS_NOT_WEBP  = 3'd4;

	localparam logic [31:0] TAG_VP8X = 32'h5650_3858;
	localparam logic [31:0] TAG_VP8L = 32'h5650_384C;
	localparam logic [31:0] TAG_VP8S = 32'h5650_3820;

	localparam logic [7:0]  VP8L_MAGIC = 8'h2f;
	localparam logic [7:0]  VP8_SYNC0  = 8'h9d;
	localparam logic [7:0]  VP8_SYNC1  = 8'h01;
	localparam logic [7:0]  VP8_SYNC2  = 8'h2a;
	localparam logic [13:0] DIM_MASK   = 14'h3fff;

	localparam logic [30:0] PIXEL_MAX  = 31'h7fff_ffff;
	localparam int          MIB_SHIFT  = 20;
	localparam logic [37:0] BASE_BYTES = 38'd67108864;
	localparam logic [31:0] MIN_WEBP   = 32'd20;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_SIG,
		OP_HDR,
		OP_DATA
	} op_t;

	typedef struct packed {
		op_t  op;
		logic cnt;
		logic fin;
		logic clr;
		logic mul;
		logic calc;
	} cmd_t;

	typedef struct packed {
		logic sat;
		logic at_start;
		logic sig_end;
		logic sig_fail;
		logic hdr_end;
		logic hdr_over;
		logic size_zero;
		logic data_end;
		logic found;
		logic over;
	} sts_t;

	function automatic logic [7:0] riff_byte(input logic [1:0] i);
		logic [7:0] v;
		unique case (i)
			2'd0: v = 8'h52;
			2'd1: v = 8'h49;
			2'd2: v = 8'h46;
			default: v = 8'h46;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] webp_byte(input logic [1:0] i);
		logic [7:0] v;
		unique case (i)
			2'd0: v = 8'h57;
			2'd1: v = 8'h45;
			2'd2: v = 8'h42;
			default: v = 8'h50;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/wps_ctrl.sv -----
module wps_ctrl import wps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic last_byte,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_SIG,
		ST_SKIP,
		ST_HDR,
		ST_DATA,
		ST_DONE,
		ST_MUL,
		ST_CALC
	} state_t;

	state_t state_q;
	state_t eff;
	state_t nxt;
	state_t fin_nxt;
	logic   out_valid_q;
	logic   parsing;
	logic   acc;

	assign parsing   = (state_q != ST_MUL) && (state_q != ST_CALC);
	assign in_ready  = parsing && (!out_valid_q || out_ready);
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign fin_nxt   = (sts.found || sts.over) ? ST_DONE : ST_SKIP;

	always_comb begin
		if (sts.sat) begin
			eff = ST_DONE;
		end else if (state_q == ST_SKIP && sts.at_start) begin
			eff = ST_HDR;
		end else begin
			eff = state_q;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_IDLE;
		cmd.cnt  = acc;
		cmd.clr  = acc && last_byte;
		cmd.mul  = (state_q == ST_MUL);
		cmd.calc = (state_q == ST_CALC);
		nxt      = eff;
		unique case (eff)
			ST_SIG: begin
				cmd.op = acc ? OP_SIG : OP_IDLE;
				if (sts.sig_end) begin
					nxt = sts.sig_fail ? ST_DONE : ST_SKIP;
				end
			end
			ST_HDR: begin
				cmd.op = acc ? OP_HDR : OP_IDLE;
				if (sts.hdr_end) begin
					if (sts.hdr_over) begin
						nxt = ST_DONE;
					end else if (sts.size_zero) begin
						cmd.fin = acc;
						nxt     = fin_nxt;
					end else begin
						nxt = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				cmd.op = acc ? OP_DATA : OP_IDLE;
				if (sts.data_end) begin
					cmd.fin = acc;
					nxt     = fin_nxt;
				end
			end
			default: begin
				nxt = eff;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SIG;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_MUL: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q     <= ST_SIG;
					out_valid_q <= 1'b1;
				end
				default: begin
					if (acc) begin
						state_q <= last_byte ? ST_MUL : nxt;
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/wps_dp.sv -----
module wps_dp import wps_pkg::*; #(
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	parameter int CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [2:0]  status,
	output logic [24:0] width,
	output logic [24:0] height,
	output logic [30:0] pixel_count,
	output logic [16:0] required_mib
);

	localparam int CNT_W = LENGTH_BITS + 1;
	localparam int POS_W = (CNT_W > 34) ? CNT_W : 34;
	localparam int OFF_W = $clog2(CAPTURE_BYTES);
	localparam logic [POS_W-1:0] LEN_LIMIT = POS_W'(1) << LENGTH_BITS;
	localparam logic [31:0] LEN_MASK =
		(LENGTH_BITS >= 32) ? 32'hffff_ffff : 32'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [31:0] CAP_N = 32'(CAPTURE_BYTES);

	logic [31:0]      len_q;
	logic [47:0]      budget_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] cs_q;
	logic [31:0]      tag_q;
	logic [31:0]      size_q;
	logic [7:0]       cap_q [CAPTURE_BYTES];
	logic [OFF_W-1:0] off_q;
	logic             sig_q;
	logic [24:0]      w_q;
	logic [24:0]      h_q;

	logic [POS_W-1:0] len_x;
	logic [POS_W-1:0] pos_d;
	logic [POS_W-1:0] next_cs;
	logic [7:0]       cap_v [CAPTURE_BYTES];
	logic [31:0]      tag_v;
	logic [31:0]      size_v;
	logic [31:0]      cap_lim;
	logic             mismatch;
	logic             sig_v;
	logic [24:0]      wv;
	logic [24:0]      hv;
	logic [27:0]      vp8l_bits;

	logic [2:0]       st_s1;
	logic             go_s1;
	logic [24:0]      w_s1;
	logic [24:0]      h_s1;
	logic [49:0]      px_s2;
	logic [37:0]      req;

	assign len_x   = POS_W'(len_q);
	assign sts.sat = (pos_q == LEN_LIMIT);
	assign pos_d   = sts.sat ? pos_q : pos_q + POS_W'(1);

	always_comb begin
		mismatch = 1'b0;
		if (pos_q < POS_W'(4)) begin
			mismatch = (data_byte != riff_byte(pos_q[1:0]));
		end else if (pos_q >= POS_W'(8) && pos_q < POS_W'(12)) begin
			mismatch = (data_byte != webp_byte(pos_q[1:0]));
		end
	end

	assign sig_v        = sig_q && !(cmd.op == OP_SIG && mismatch);
	assign sts.at_start = (pos_q == cs_q);
	assign sts.sig_end  = (pos_q == POS_W'(11));
	assign sts.sig_fail = !sig_v || (len_q < MIN_WEBP) || (cs_q + POS_W'(8) > len_x);

	always_comb begin
		tag_v  = tag_q;
		size_v = size_q;
		if (cmd.op == OP_HDR) begin
			unique case (off_q)
				OFF_W'(0): begin
					tag_v  = {tag_q[23:0], data_byte};
					size_v = '0;
				end
				OFF_W'(1), OFF_W'(2), OFF_W'(3): tag_v = {tag_q[23:0], data_byte};
				OFF_W'(4): size_v[7:0]   = data_byte;
				OFF_W'(5): size_v[15:8]  = data_byte;
				OFF_W'(6): size_v[23:16] = data_byte;
				OFF_W'(7): size_v[31:24] = data_byte;
				default: size_v = size_q;
			endcase
		end
	end

	assign sts.hdr_end   = (off_q == OFF_W'(7));
	assign sts.hdr_over  = (cs_q + POS_W'(8) > len_x) ||
		(POS_W'(size_v) > len_x - cs_q - POS_W'(8));
	assign sts.size_zero = (size_v == 32'd0);
	assign cap_lim       = (size_q < CAP_N) ? size_q : CAP_N;
	assign sts.data_end  = (32'(off_q) + 32'd1 >= cap_lim);

	always_comb begin
		for (int i = 0; i < CAPTURE_BYTES; i++) begin
			cap_v[i] = (cmd.op == OP_DATA && off_q == OFF_W'(i)) ? data_byte : cap_q[i];
		end
	end

	assign vp8l_bits = {cap_v[4][3:0], cap_v[3], cap_v[2], cap_v[1]};

	always_comb begin
		wv = w_q;
		hv = h_q;
		if (tag_v == TAG_VP8X && size_v >= 32'd10) begin
			wv = 25'({cap_v[6], cap_v[5], cap_v[4]}) + 25'd1;
			hv = 25'({cap_v[9], cap_v[8], cap_v[7]}) + 25'd1;
		end else if (tag_v == TAG_VP8L && size_v >= 32'd5 && cap_v[0] == VP8L_MAGIC) begin
			wv = 25'(vp8l_bits[13:0]) + 25'd1;
			hv = 25'(vp8l_bits[27:14]) + 25'd1;
		end else if (tag_v == TAG_VP8S && size_v >= 32'd10 && !cap_v[0][0] &&
				cap_v[3] == VP8_SYNC0 && cap_v[4] == VP8_SYNC1 &&
				cap_v[5] == VP8_SYNC2) begin
			wv = 25'({cap_v[7][5:0], cap_v[6]} & DIM_MASK);
			hv = 25'({cap_v[9][5:0], cap_v[8]} & DIM_MASK);
		end
	end

	assign sts.found = (wv != '0) && (hv != '0);
	assign next_cs   = cs_q + POS_W'(8) + POS_W'(size_v) + POS_W'(size_v[0]);
	assign sts.over  = (next_cs + POS_W'(8) > len_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			budget_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_LENGTH) begin
				len_q <= cfg_data[31:0] & LEN_MASK;
			end else if (cfg_index == REG_MEMORY_BUDGET) begin
				budget_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cs_q   <= POS_W'(12);
			tag_q  <= '0;
			size_q <= '0;
			off_q  <= '0;
			sig_q  <= 1'b1;
			w_q    <= '0;
			h_q    <= '0;
			for (int i = 0; i < CAPTURE_BYTES; i++) begin
				cap_q[i] <= '0;
			end
		end else if (cmd.clr) begin
			pos_q  <= '0;
			cs_q   <= POS_W'(12);
			tag_q  <= '0;
			size_q <= '0;
			off_q  <= '0;
			sig_q  <= 1'b1;
			w_q    <= '0;
			h_q    <= '0;
			for (int i = 0; i < CAPTURE_BYTES; i++) begin
				cap_q[i] <= '0;
			end
		end else if (cmd.cnt) begin
			pos_q <= pos_d;
			sig_q <= sig_v;
			if (cmd.op == OP_HDR) begin
				tag_q  <= tag_v;
				size_q <= size_v;
				off_q  <= sts.hdr_end ? '0 : off_q + OFF_W'(1);
			end
			if (cmd.op == OP_DATA) begin
				cap_q[off_q] <= data_byte;
				off_q        <= off_q + OFF_W'(1);
			end
			if (cmd.fin) begin
				w_q   <= wv;
				h_q   <= hv;
				off_q <= '0;
				if (!sts.found) begin
					cs_q <= next_cs;
				end
			end
		end
	end

	assign req = 38'({px_s2[30:0], 5'b0}) + 38'({px_s2[30:0], 3'b0}) + BASE_BYTES;

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			go_s1 <= 1'b0;
			w_s1  <= '0;
			h_s1  <= '0;
			if (len_q == 32'd0) begin
				st_s1 <= STATUS_INVALID;
			end else if (48'(len_q) > (budget_q >> 2)) begin
				st_s1 <= STATUS_MEM_LIMIT;
			end else if (pos_d != len_x) begin
				st_s1 <= STATUS_INVALID;
			end else if (len_q < MIN_WEBP || !sig_v) begin
				st_s1 <= STATUS_NOT_WEBP;
			end else begin
				w_s1 <= cmd.fin ? wv : w_q;
				h_s1 <= cmd.fin ? hv : h_q;
				if ((cmd.fin ? wv : w_q) == '0 || (cmd.fin ? hv : h_q) == '0) begin
					st_s1 <= STATUS_INVALID;
				end else begin
					st_s1 <= STATUS_OK;
					go_s1 <= 1'b1;
				end
			end
		end
		if (cmd.mul) begin
			px_s2 <= 50'(w_s1) * 50'(h_s1);
		end
		if (cmd.calc) begin
			width        <= w_s1;
			height       <= h_s1;
			pixel_count  <= '0;
			required_mib <= '0;
			if (!go_s1) begin
				status <= st_s1;
			end else if (px_s2 > 50'(PIXEL_MAX)) begin
				status <= STATUS_TOO_LARGE;
			end else begin
				required_mib <= req[36:MIB_SHIFT] + 17'(|req[MIB_SHIFT-1:0]);
				if (48'(req) > budget_q) begin
					status <= STATUS_MEM_LIMIT;
				end else begin
					status      <= STATUS_OK;
					pixel_count <= px_s2[30:0];
				end
			end
		end
	end

endmodule

// ----- rtl/webp_header_size_check.sv -----
// Streams an encoded image in one byte per cycle (in_valid/in_ready) and issues a single verdict
// item after the byte marked last: status, parsed width and height, pixel count and working set
// in MiB. Program image_length and memory_budget through the configuration channel while the
// block is idle; cfg_ready is always high. Bytes are taken at one per cycle while a stream is
// parsed. After the last byte the verdict is produced in the ST_MUL state by the width-by-height
// multiplier and then in the ST_CALC state by the working-set sum and budget compare, and the
// verdict then sits in the output register until out_ready. Input is held off in those states
// and whenever a verdict is still waiting and out_ready is low. No clearing pass follows reset.
module webp_header_size_check import wps_pkg::*; #(
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	parameter int CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [24:0] width,
	output logic [24:0] height,
	output logic [30:0] pixel_count,
	output logic [16:0] required_mib
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	wps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wps_dp #(
		.LENGTH_BITS   (LENGTH_BITS),
		.CAPTURE_BYTES (CAPTURE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_byte    (data_byte),
		.cmd          (cmd),
		.sts          (sts),
		.status       (status),
		.width        (width),
		.height       (height),
		.pixel_count  (pixel_count),
		.required_mib (required_mib)
	);

endmodule

// ----- rtl/wps_chk.sv -----
module wps_chk import wps_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [24:0] width,
	input logic [24:0] height,
	input logic [30:0] pixel_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pixel_count))
		else $error("verdict changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STATUS_NOT_WEBP)
		else $error("status code out of range");

	a_pixels_ok_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> pixel_count == '0)
		else $error("pixel count on failing verdict");

	a_not_webp_dims: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_NOT_WEBP |-> width == '0 && height == '0)
		else $error("dimensions reported for non-webp image");

	a_verdict_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte |=> !in_ready)
		else $error("input taken during verdict");

endmodule

bind webp_header_size_check wps_chk u_chk (.*);
